@@ src/lkvc_pkg.sv @@
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared types and constants for the LRU key-value cache.
// ----------------------------------------------------------------------------
package lkvc_pkg;

   localparam int LKVC_MAX_ENTRIES = 16;
   localparam int LKVC_VALUE_BITS  = 32;

   localparam int KEY_W  = 32;
   localparam int DATA_W = 32;
   localparam int CAP_W  = 5;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   typedef enum logic {
      MODE_GET = 1'b0,
      MODE_PUT = 1'b1
   } mode_type;

   typedef enum logic [2:0] {
      ST_GET_MISS     = 3'd0,
      ST_GET_HIT      = 3'd1,
      ST_PUT_UPDATED  = 3'd2,
      ST_PUT_INSERTED = 3'd3,
      ST_PUT_EVICTED  = 3'd4
   } status_type;

   typedef struct packed {
      mode_type                 mode;
      logic signed [KEY_W-1:0]  key;
      logic [DATA_W-1:0]        value;
   } req_type;

   typedef struct packed {
      status_type               status;
      logic [DATA_W-1:0]        value_out;
      logic signed [KEY_W-1:0]  evicted_key;
      logic [DATA_W-1:0]        evicted_value;
   } rsp_type;

endpackage

@@ src/lru_key_value_cache.sv @@
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key-value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Each request transaction (get or put of a signed key) produces exactly one
// response transaction. A request is captured in an input register; once the
// output register can take a response, all entries are compared against its
// key in parallel, the recency ranks and stores are updated and the response
// is loaded into the output register. One transaction is taken every clock
// while the response side does not stall. That rate is set by the parallel
// key compare and rank update over all MAX_ENTRIES entries. The store is
// empty after reset with no clearing pass; capacity
// (0 acts as 1, values above MAX_ENTRIES saturate) must be written only while
// the cache is idle. A put of an absent key into a full cache evicts the
// least recent entry and reports its key and value.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
   parameter int MAX_ENTRIES = lkvc_pkg::LKVC_MAX_ENTRIES,
   parameter int VALUE_BITS  = lkvc_pkg::LKVC_VALUE_BITS
) (
   input  logic                         clock,
   input  logic                         reset,

   input  logic                         csr_wr_en,
   input  logic [lkvc_pkg::CAP_W-1:0]   csr_wr_data,

   input  logic                         req_valid,
   output logic                         req_stall,
   input  lkvc_pkg::req_type            req_payload,

   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output lkvc_pkg::rsp_type            rsp_payload
);

   localparam int STORE_W = (VALUE_BITS < lkvc_pkg::DATA_W) ? VALUE_BITS : lkvc_pkg::DATA_W;
   localparam int RANK_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int OCC_W   = $clog2(MAX_ENTRIES + 1);

   logic [lkvc_pkg::CAP_W-1:0]     capacity_ff;

   logic                           in_valid_ff, in_valid_in;
   lkvc_pkg::req_type              req_ff;

   logic                           rsp_valid_ff, rsp_valid_in;
   lkvc_pkg::rsp_type              rsp_ff, rsp_in;

   logic [lkvc_pkg::KEY_W-1:0]     key_mem   [MAX_ENTRIES];
   logic [STORE_W-1:0]             value_mem [MAX_ENTRIES];

   logic [MAX_ENTRIES-1:0]         valid_ff, valid_in;
   logic [RANK_W-1:0]              rank_ff [MAX_ENTRIES];
   logic [RANK_W-1:0]              rank_in [MAX_ENTRIES];
   logic [OCC_W-1:0]               occ_ff, occ_in;

   logic                           advance;
   logic                           do_item;
   logic [MAX_ENTRIES-1:0]         hit_vec;
   logic [MAX_ENTRIES-1:0]         lru_vec;
   logic [MAX_ENTRIES-1:0]         free_vec;
   logic [MAX_ENTRIES-1:0]         slot_vec;
   logic [MAX_ENTRIES-1:0]         wr_vec;
   logic                           hit;
   logic                           evict;
   logic [RANK_W-1:0]              hit_rank;
   logic [RANK_W-1:0]              lru_rank;
   logic [OCC_W-1:0]               cap_eff;
   logic [STORE_W-1:0]             hit_value;
   logic [STORE_W-1:0]             lru_value;
   logic [lkvc_pkg::KEY_W-1:0]     lru_key;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign do_item   = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      if (capacity_ff == '0) begin
         cap_eff = OCC_W'(1);
      end else if (int'(capacity_ff) > MAX_ENTRIES) begin
         cap_eff = OCC_W'(MAX_ENTRIES);
      end else begin
         cap_eff = OCC_W'(capacity_ff);
      end
   end

   assign lru_rank = RANK_W'(occ_ff - OCC_W'(1));
   assign evict    = occ_ff >= cap_eff;

   always_comb begin
      hit_rank  = '0;
      hit_value = '0;
      lru_value = '0;
      lru_key   = '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         hit_vec[i] = valid_ff[i] && (key_mem[i] == req_ff.key);
         lru_vec[i] = valid_ff[i] && (rank_ff[i] == lru_rank);
         if (hit_vec[i]) begin
            hit_rank  = hit_rank | rank_ff[i];
            hit_value = hit_value | value_mem[i];
         end
         if (lru_vec[i]) begin
            lru_value = lru_value | value_mem[i];
            lru_key   = lru_key | key_mem[i];
         end
      end
   end

   assign hit      = |hit_vec;
   assign free_vec = ~valid_ff | (evict ? lru_vec : '0);
   assign slot_vec = free_vec & (~free_vec + MAX_ENTRIES'(1));

   always_comb begin
      valid_in     = valid_ff;
      rank_in      = rank_ff;
      occ_in       = occ_ff;
      wr_vec       = '0;
      rsp_in       = '0;
      rsp_in.status = lkvc_pkg::ST_GET_MISS;
      if (do_item) begin
         if (hit) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
               if (hit_vec[i]) begin
                  rank_in[i] = '0;
               end else if (valid_ff[i] && (rank_ff[i] < hit_rank)) begin
                  rank_in[i] = rank_ff[i] + RANK_W'(1);
               end
            end
            if (req_ff.mode == lkvc_pkg::MODE_GET) begin
               rsp_in.status    = lkvc_pkg::ST_GET_HIT;
               rsp_in.value_out = lkvc_pkg::DATA_W'(hit_value);
            end else begin
               rsp_in.status = lkvc_pkg::ST_PUT_UPDATED;
               wr_vec        = hit_vec;
            end
         end else if (req_ff.mode == lkvc_pkg::MODE_PUT) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
               if (slot_vec[i]) begin
                  valid_in[i] = 1'b1;
                  rank_in[i]  = '0;
               end else if (evict && lru_vec[i]) begin
                  valid_in[i] = 1'b0;
                  rank_in[i]  = '0;
               end else if (valid_ff[i]) begin
                  rank_in[i] = rank_ff[i] + RANK_W'(1);
               end
            end
            wr_vec = slot_vec;
            if (evict) begin
               rsp_in.status        = lkvc_pkg::ST_PUT_EVICTED;
               rsp_in.evicted_key   = lru_key;
               rsp_in.evicted_value = lkvc_pkg::DATA_W'(lru_value);
            end else begin
               rsp_in.status = lkvc_pkg::ST_PUT_INSERTED;
               occ_in        = occ_ff + OCC_W'(1);
            end
         end
      end
   end

   always_comb begin
      if (req_valid && !req_stall) begin
         in_valid_in = 1'b1;
      end else if (do_item) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_comb begin
      if (do_item) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= lkvc_pkg::CAP_RESET;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
         occ_ff       <= '0;
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            capacity_ff <= csr_wr_data;
         end
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         valid_ff     <= valid_in;
         occ_ff       <= occ_in;
         rank_ff      <= rank_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         req_ff <= req_payload;
      end
      if (do_item) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         if (wr_vec[i]) begin
            key_mem[i]   <= req_ff.key;
            value_mem[i] <= req_ff.value[STORE_W-1:0];
         end
      end
   end

endmodule

@@ bench/lru_key_value_cache_checker.sv @@
// ----------------------------------------------------------------------------
// lru_key_value_cache_checker
// Monitors the request, response and csr ports of the LRU key-value cache.
// Each accepted request is run through a behavioral copy of the cache
// (key match, recency ranks, capacity clamp, eviction of the least
// recent entry), and the predicted response is queued. Each accepted response
// is compared field by field against the oldest queued prediction.
// ----------------------------------------------------------------------------
module lru_key_value_cache_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [lkvc_pkg::CAP_W-1:0]    csr_wr_data,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  lkvc_pkg::req_type             req_payload,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  lkvc_pkg::rsp_type             rsp_payload,
   output int                            mismatch_count,
   output int                            pending_count
);

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS = lkvc_pkg::LKVC_MAX_ENTRIES;
   localparam logic [lkvc_pkg::DATA_W-1:0] VALUE_MASK =
      {lkvc_pkg::DATA_W{1'b1}} >> (lkvc_pkg::DATA_W - lkvc_pkg::LKVC_VALUE_BITS);

   logic [lkvc_pkg::KEY_W-1:0]   slot_key   [SLOTS];
   logic [lkvc_pkg::DATA_W-1:0]  slot_value [SLOTS];
   bit                           slot_used  [SLOTS];
   int unsigned                  slot_age   [SLOTS];
   int unsigned                  fill_level = 0;
   logic [lkvc_pkg::CAP_W-1:0]   capacity_reg = lkvc_pkg::CAP_RESET;
   lkvc_pkg::rsp_type            pending_responses [$];

   initial begin
      mismatch_count = 0;
      pending_count  = 0;
      foreach (slot_used[i]) begin
         slot_used[i] = 1'b0;
         slot_age[i]  = 0;
      end
   end

   // entries more recent than idx age by one; idx becomes most recent
   function automatic void promote(input int idx);
      int unsigned r;
      r = slot_age[idx];
      for (int i = 0; i < SLOTS; i++) begin
         if (slot_used[i] && slot_age[i] < r) slot_age[i]++;
      end
      slot_age[idx] = 0;
   endfunction

   function automatic lkvc_pkg::rsp_type cache_access(input lkvc_pkg::req_type r);
      lkvc_pkg::rsp_type res;
      int                hit;
      int                lru;
      int                free_slot;
      int unsigned       limit;
      res = '0;
      hit = -1;
      for (int i = 0; i < SLOTS; i++) begin
         if (hit < 0 && slot_used[i] && slot_key[i] == r.key) hit = i;
      end
      if (r.mode == lkvc_pkg::MODE_GET) begin
         if (hit >= 0) begin
            promote(hit);
            res.value_out = slot_value[hit];
            res.status    = lkvc_pkg::ST_GET_HIT;
         end else begin
            res.status = lkvc_pkg::ST_GET_MISS;
         end
      end else if (hit >= 0) begin
         slot_value[hit] = r.value & VALUE_MASK;
         promote(hit);
         res.status = lkvc_pkg::ST_PUT_UPDATED;
      end else begin
         res.status = lkvc_pkg::ST_PUT_INSERTED;
         limit = (capacity_reg == 0) ? 1 : capacity_reg;
         if (limit > SLOTS) limit = SLOTS;
         if (fill_level >= limit) begin
            lru = -1;
            for (int i = 0; i < SLOTS; i++) begin
               if (slot_used[i] && (lru < 0 || slot_age[i] > slot_age[lru])) lru = i;
            end
            if (lru >= 0) begin
               res.evicted_key   = slot_key[lru];
               res.evicted_value = slot_value[lru];
               slot_used[lru]    = 1'b0;
               slot_age[lru]     = 0;
               if (fill_level > 0) fill_level--;
               res.status = lkvc_pkg::ST_PUT_EVICTED;
            end
         end
         free_slot = -1;
         for (int i = 0; i < SLOTS; i++) begin
            if (free_slot < 0 && !slot_used[i]) free_slot = i;
         end
         if (free_slot >= 0) begin
            for (int i = 0; i < SLOTS; i++) begin
               if (slot_used[i]) slot_age[i]++;
            end
            slot_key[free_slot]   = r.key;
            slot_value[free_slot] = r.value & VALUE_MASK;
            slot_used[free_slot]  = 1'b1;
            slot_age[free_slot]   = 0;
            fill_level++;
         end
      end
      return res;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %h, got %h", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      lkvc_pkg::rsp_type want;
      if (reset) begin
         foreach (slot_used[i]) begin
            slot_used[i] = 1'b0;
            slot_age[i]  = 0;
         end
         fill_level   = 0;
         capacity_reg = lkvc_pkg::CAP_RESET;
         pending_responses.delete();
      end else begin
         if (csr_wr_en) capacity_reg = csr_wr_data;
         if (req_valid && !req_stall) pending_responses.push_back(cache_access(req_payload));
         if (rsp_valid && !rsp_stall) begin
            if (pending_responses.size() == 0) begin
               $error("response transaction with no request outstanding");
               mismatch_count++;
            end else begin
               want = pending_responses.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_payload.status));
               check_field("value_out", want.value_out, rsp_payload.value_out);
               check_field("evicted_key", want.evicted_key, rsp_payload.evicted_key);
               check_field("evicted_value", want.evicted_value, rsp_payload.evicted_value);
            end
         end
      end
      pending_count = pending_responses.size();
   end

endmodule

@@ bench/lru_key_value_cache_tb.sv @@
// ----------------------------------------------------------------------------
// lru_key_value_cache_tb
// Stimulus and verdict for the LRU key-value cache.
// A directed sequence hits empty lookups, extreme keys and values, updates,
// a full cache and a capacity cut below occupancy. Random phases then run
// gets and puts over small key pools at several capacities (zero, one,
// sixteen, above the entry count and random), with random gaps on the
// request side and random stalls on the response side. Checking is done in
// the checker module; a watchdog ends a run that stops moving.
// ----------------------------------------------------------------------------
module lru_key_value_cache_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int PHASES          = 10;
   localparam int ITEMS_PER_PHASE = 168;
   localparam int WATCHDOG_LIMIT  = 1000;
   localparam logic [lkvc_pkg::KEY_W-1:0] KEY_MIN = 32'h8000_0000;
   localparam logic [lkvc_pkg::KEY_W-1:0] KEY_MAX = 32'h7FFF_FFFF;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        csr_wr_en = 1'b0;
   logic [lkvc_pkg::CAP_W-1:0]  csr_wr_data = '0;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   lkvc_pkg::req_type           req_payload = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   lkvc_pkg::rsp_type           rsp_payload;

   int                mismatch_count;
   int                pending_count;
   int                idle_cycles = 0;
   bit                req_quiet = 1'b0;
   bit                rsp_quiet = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   lru_key_value_cache uut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   lru_key_value_cache_checker cache_check (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_payload    (rsp_payload),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   // called at a falling edge, returns at a falling edge
   task automatic send_req(input lkvc_pkg::mode_type m,
                           input logic [lkvc_pkg::KEY_W-1:0] k,
                           input logic [lkvc_pkg::DATA_W-1:0] v);
      int gap;
      if ($urandom_range(0, 49) == 0) req_quiet = !req_quiet;
      gap = req_quiet ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        = 1'b1;
      req_payload.mode  = m;
      req_payload.key   = k;
      req_payload.value = v;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid = 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_capacity(input logic [lkvc_pkg::CAP_W-1:0] c);
      wait_drained();
      csr_wr_en   = 1'b1;
      csr_wr_data = c;
      @(negedge clock);
      csr_wr_en   = 1'b0;
   endtask

   function automatic logic [lkvc_pkg::DATA_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [lkvc_pkg::KEY_W-1:0] pick_pool_key();
      case ($urandom_range(0, 11))
         0: return KEY_MIN;
         1: return KEY_MAX;
         2: return '0;
         3: return '1;
         default: return $urandom;
      endcase
   endfunction

   // response side: stall for a drawn number of cycles before each transaction
   initial begin
      int n;
      @(negedge clock);
      forever begin
         if ($urandom_range(0, 49) == 0) rsp_quiet = !rsp_quiet;
         n = rsp_quiet ? 0 : $urandom_range(0, 19);
         rsp_stall = (n > 0);
         repeat (n) @(negedge clock);
         rsp_stall = 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [lkvc_pkg::KEY_W-1:0] key_pool [32];
      int                         pool_size;
      logic [lkvc_pkg::KEY_W-1:0] k;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed
      send_req(lkvc_pkg::MODE_GET, KEY_MIN, 32'hDEAD_BEEF);
      send_req(lkvc_pkg::MODE_PUT, KEY_MIN, 32'h0000_0000);
      send_req(lkvc_pkg::MODE_PUT, KEY_MAX, 32'hFFFF_FFFF);
      send_req(lkvc_pkg::MODE_GET, KEY_MAX, 32'h1234_5678);
      send_req(lkvc_pkg::MODE_GET, KEY_MIN, 32'h0000_0000);
      send_req(lkvc_pkg::MODE_PUT, KEY_MIN, 32'hA5A5_A5A5);
      send_req(lkvc_pkg::MODE_GET, 32'h0, 32'h0);
      send_req(lkvc_pkg::MODE_PUT, 32'h0, 32'h5A5A_5A5A);
      for (int i = 1; i <= 13; i++) begin
         send_req(lkvc_pkg::MODE_PUT, 32'(i), 32'(i * 32'h0101_0101));
      end
      send_req(lkvc_pkg::MODE_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      // capacity cut below occupancy
      set_capacity(5'd3);
      send_req(lkvc_pkg::MODE_PUT, 32'd100, 32'h0F0F_0F0F);
      send_req(lkvc_pkg::MODE_PUT, 32'd101, 32'hF0F0_F0F0);
      send_req(lkvc_pkg::MODE_GET, KEY_MIN, 32'h0);

      // random phases
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: set_capacity(5'd16);
            1: set_capacity(5'd1);
            2: set_capacity(5'd0);
            3: set_capacity(5'd31);
            default: set_capacity(lkvc_pkg::CAP_W'($urandom_range(0, 31)));
         endcase
         pool_size = $urandom_range(1, 24);
         for (int i = 0; i < pool_size; i++) key_pool[i] = pick_pool_key();
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if ($urandom_range(0, 99) < 85) k = key_pool[$urandom_range(0, pool_size - 1)];
            else k = $urandom;
            send_req($urandom_range(0, 1) ? lkvc_pkg::MODE_PUT : lkvc_pkg::MODE_GET,
                     k, pick_value());
         end
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

@@ sim.f @@
src/lkvc_pkg.sv
src/lru_key_value_cache.sv
bench/lru_key_value_cache_checker.sv
bench/lru_key_value_cache_tb.sv
